// ===== src/ssu_pkg.sv =====
package ssu_pkg;

	localparam int LAYERS = 4;
	localparam int CHANNELS = 64;
	localparam int STATES = 16;
	localparam int DEPTH = LAYERS * CHANNELS * STATES;
	localparam int AW = $clog2(DEPTH);
	localparam int QDEPTH = 2;

	localparam int QW = 32;
	localparam int FRAC = 16;
	localparam logic signed [QW-1:0] Q_ONE = 32'sd65536;
	localparam logic signed [QW-1:0] FLOOR_RESET = -32'sd124518;
	localparam logic signed [QW-1:0] QMAX = 32'sh7fffffff;
	localparam logic signed [QW-1:0] QMIN = 32'sh80000000;

	typedef logic signed [QW-1:0] q_t;

	// one classified item as it waits between front and back
	typedef struct packed {
		logic [AW-1:0] addr;
		logic last;
		logic [5:0] ch;
		logic [30:0] delta;
		logic [32*6-1:0] vals;
	} item_t;

	// saturate a 66-bit signed value to Q16.16
	function automatic q_t sat32(input logic signed [65:0] x, output logic ovf);
		begin
			ovf = 1'b0;
			sat32 = x[QW-1:0];
			if (x > 66'sh0_7fff_ffff) begin
				ovf = 1'b1;
				sat32 = QMAX;
			end else if (x < -66'sh0_8000_0000) begin
				ovf = 1'b1;
				sat32 = QMIN;
			end
		end
	endfunction

	// product shifted right by 16 (floor), sign-extended to 66 bits
	function automatic logic signed [65:0] pshift(input logic signed [63:0] p);
		begin
			pshift = 66'(p >>> FRAC);
		end
	endfunction

endpackage

// ===== src/ssu_if.sv =====
interface ssu_in_if;
	logic valid;
	logic ready;
	logic [1:0] layer_index;
	logic [5:0] channel;
	logic [3:0] state_index;
	logic [30:0] delta;
	logic signed [31:0] a_coef;
	logic signed [31:0] b_val;
	logic signed [31:0] c_val;
	logic signed [31:0] u_val;
	logic signed [31:0] d_skip;
	logic signed [31:0] gate;
	modport source (output valid, layer_index, channel, state_index, delta, a_coef, b_val,
		c_val, u_val, d_skip, gate, input ready);
	modport sink (input valid, layer_index, channel, state_index, delta, a_coef, b_val,
		c_val, u_val, d_skip, gate, output ready);
endinterface

interface ssu_out_if;
	logic valid;
	logic ready;
	logic [5:0] out_channel;
	logic signed [31:0] y_out;
	logic saturated;
	modport source (output valid, out_channel, y_out, saturated, input ready);
	modport sink (input valid, out_channel, y_out, saturated, output ready);
endinterface

// ===== src/selective_scan_state_update.sv =====
// Items wait in a two-entry queue and the back end processes one at a time: steps M0 to M6
// for every element, and M7 to M9 too on a channel's last, whose result is then registered.
// The back end takes no new item until it is through with the last one; its steps share one
// 32x32 multiplier. A result not yet taken holds the final step.
// Reset clears control, the running sum and the flags and sets the floor to FLOOR_RESET;
// then a pass over all 4096 entries clears the hidden-state memory before any item runs.
module selective_scan_state_update (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic signed [31:0] cfg_wdata,
	ssu_in_if.sink in,
	ssu_out_if.source out
);
	import ssu_pkg::*;

	q_t floor_q;
	logic q_valid, q_ready, q_last;
	logic [AW-1:0] q_addr;
	logic [5:0] q_ch;
	logic [30:0] q_delta;
	logic [32*6-1:0] q_vals;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) floor_q <= FLOOR_RESET;
		else if (cfg_we) floor_q <= cfg_wdata;
	end

	ssu_front u_front (
		.clk(clk), .arst_n(arst_n), .in(in),
		.push_ready(q_ready), .push_valid(q_valid), .push_addr(q_addr),
		.push_last(q_last), .push_ch(q_ch), .push_delta(q_delta), .push_vals(q_vals)
	);

	ssu_back u_back (
		.clk(clk), .arst_n(arst_n), .decay_floor(floor_q),
		.pop_valid(q_valid), .pop_ready(q_ready), .pop_addr(q_addr),
		.pop_last(q_last), .pop_ch(q_ch), .pop_delta(q_delta), .pop_vals(q_vals),
		.out(out)
	);
endmodule

// ===== src/ssu_front.sv =====
module ssu_front (
	input  logic clk,
	input  logic arst_n,
	ssu_in_if.sink in,
	input  logic push_ready,
	output logic push_valid,
	output logic [ssu_pkg::AW-1:0] push_addr,
	output logic push_last,
	output logic [5:0] push_ch,
	output logic [30:0] push_delta,
	output logic [32*6-1:0] push_vals
);
	import ssu_pkg::*;

	item_t item;
	item_t fifo_q [QDEPTH];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic do_push, do_pop;

	// sizes are powers of two, so the index fields map straight onto the address
	always_comb begin
		item.addr = {in.layer_index, in.channel, in.state_index};
		item.last = (in.state_index == 4'(STATES - 1));
		item.ch = in.channel;
		item.delta = in.delta;
		item.vals = {in.a_coef, in.b_val, in.c_val, in.u_val, in.d_skip, in.gate};
	end

	assign in.ready = (cnt_q != 2'(QDEPTH));
	assign push_valid = (cnt_q != 2'd0);
	assign do_push = in.valid && in.ready;
	assign do_pop = push_valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			unique case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) fifo_q[wr_ptr_q] <= item;
	end

	assign push_addr = fifo_q[rd_ptr_q].addr;
	assign push_last = fifo_q[rd_ptr_q].last;
	assign push_ch = fifo_q[rd_ptr_q].ch;
	assign push_delta = fifo_q[rd_ptr_q].delta;
	assign push_vals = fifo_q[rd_ptr_q].vals;
endmodule

// ===== src/ssu_back.sv =====
module ssu_back (
	input  logic clk,
	input  logic arst_n,
	input  logic signed [31:0] decay_floor,
	input  logic pop_valid,
	output logic pop_ready,
	input  logic [ssu_pkg::AW-1:0] pop_addr,
	input  logic pop_last,
	input  logic [5:0] pop_ch,
	input  logic [30:0] pop_delta,
	input  logic [32*6-1:0] pop_vals,
	ssu_out_if.source out
);
	import ssu_pkg::*;

	typedef enum logic [11:0] {
		S_CLR  = 12'b0000_0000_0001,
		S_IDLE = 12'b0000_0000_0010,
		S_M0   = 12'b0000_0000_0100,
		S_M1   = 12'b0000_0000_1000,
		S_M2   = 12'b0000_0001_0000,
		S_M3   = 12'b0000_0010_0000,
		S_M4   = 12'b0000_0100_0000,
		S_M5   = 12'b0000_1000_0000,
		S_M6   = 12'b0001_0000_0000,
		S_M7   = 12'b0010_0000_0000,
		S_M8   = 12'b0100_0000_0000,
		S_M9   = 12'b1000_0000_0000
	} st_t;

	st_t st_q;
	q_t mem [DEPTH];
	logic [AW-1:0] clr_q, addr_q;
	logic last_q;
	logic [5:0] ch_q, och_q;
	logic [30:0] dl_q;
	q_t a_q, b_q, c_q, u_q, d_q, g_q, hr_q;
	q_t abar_q, bbar_q, h_q, sum_q, tot_q, y_q;
	logic signed [63:0] p_q, p2_q;
	logic flag_q, sat_q, ov_q, y_v_q;
	logic pop_go, y_go;
	logic signed [31:0] ma, mb;
	logic signed [63:0] mp;
	logic o1, o2, o3, o4, o5, o6, o7, o8;
	q_t da, ab, bb, hn, hc, sn, tn, yn;

	assign pop_ready = (st_q == S_IDLE);
	assign pop_go = pop_valid && pop_ready;
	// a result not yet taken holds only the final step
	assign y_go = (st_q == S_M9) && (!y_v_q || out.ready);

	// shared multiplier
	always_comb begin
		ma = a_q;
		mb = $signed({1'b0, dl_q});
		unique case (st_q)
			S_M1: ma = b_q;
			S_M2: begin ma = abar_q; mb = hr_q; end
			S_M3: begin ma = bbar_q; mb = u_q; end
			S_M5: begin ma = h_q; mb = c_q; end
			S_M6: begin ma = u_q; mb = d_q; end
			S_M8: begin ma = tot_q; mb = g_q; end
			default: ;
		endcase
	end
	assign mp = 64'(ma) * 64'(mb);

	always_comb begin
		da = sat32(pshift(p_q), o1);
		if (da < decay_floor) da = decay_floor;
		ab = sat32(66'(da) + 66'(Q_ONE), o2);
		bb = sat32(pshift(p_q), o3);
		hn = sat32(pshift(p2_q) + pshift(p_q), o4);
		hc = sat32(pshift(p_q), o5);
		sn = sat32(66'(sum_q) + 66'(hc), o6);
		tn = sat32(66'(sum_q) + pshift(p_q), o7);
		yn = sat32(pshift(p_q), o8);
	end

	always_ff @(posedge clk) begin
		if (st_q == S_CLR) mem[clr_q] <= '0;
		else if (st_q == S_M4) mem[addr_q] <= hn;
		if (pop_go) hr_q <= mem[pop_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			clr_q <= '0;
			sum_q <= '0;
			sat_q <= 1'b0;
			flag_q <= 1'b0;
			y_v_q <= 1'b0;
		end else begin
			if (y_go) y_v_q <= 1'b1;
			else if (out.ready) y_v_q <= 1'b0;
			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) st_q <= S_IDLE;
				end
				S_IDLE: if (pop_go) begin
					flag_q <= 1'b0;
					st_q <= S_M0;
				end
				S_M0: st_q <= S_M1;
				S_M1: begin flag_q <= flag_q | o1 | o2; st_q <= S_M2; end
				S_M2: begin flag_q <= flag_q | o3; st_q <= S_M3; end
				S_M3: st_q <= S_M4;
				S_M4: begin flag_q <= flag_q | o4; st_q <= S_M5; end
				S_M5: st_q <= S_M6;
				S_M6: begin
					sum_q <= sn;
					if (last_q) begin
						flag_q <= flag_q | o5 | o6;
						st_q <= S_M7;
					end else begin
						sat_q <= sat_q | flag_q | o5 | o6;
						st_q <= S_IDLE;
					end
				end
				S_M7: begin flag_q <= flag_q | o7; st_q <= S_M8; end
				S_M8: st_q <= S_M9;
				S_M9: if (y_go) begin
					sum_q <= '0;
					sat_q <= 1'b0;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop_go) begin
			{a_q, b_q, c_q, u_q, d_q, g_q} <= pop_vals;
			addr_q <= pop_addr;
			last_q <= pop_last;
			ch_q <= pop_ch;
			dl_q <= pop_delta;
		end
		unique case (st_q)
			S_M0, S_M1, S_M2, S_M3, S_M5, S_M6, S_M8: p_q <= mp;
			default: ;
		endcase
		if (st_q == S_M1) abar_q <= ab;
		if (st_q == S_M2) bbar_q <= bb;
		if (st_q == S_M3) p2_q <= p_q;
		if (st_q == S_M4) h_q <= hn;
		if (st_q == S_M7) tot_q <= tn;
		if (y_go) begin
			y_q <= yn;
			och_q <= ch_q;
			ov_q <= sat_q | flag_q | o8;
		end
	end

	assign out.valid = y_v_q;
	assign out.out_channel = och_q;
	assign out.y_out = y_q;
	assign out.saturated = ov_q;
endmodule

// ===== tb/sv/ssu_tb_if.sv =====
interface ssu_cfg_if;
	logic we;
	logic signed [31:0] wdata;
endinterface

// ===== tb/sv/testbench.sv =====
module testbench;
	import ssu_pkg::*;

	localparam int NL = 4;
	localparam int NC = 64;
	localparam int NS = 16;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_LEN = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ssu_in_if in_ch();
	ssu_out_if out_ch();
	ssu_cfg_if cfg_ch();

	selective_scan_state_update dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_ch.we), .cfg_wdata(cfg_ch.wdata),
		.in(in_ch.sink), .out(out_ch.source)
	);

	always #2 clk = ~clk;

	typedef struct packed {
		logic [5:0] ch;
		logic signed [31:0] y;
		logic sat;
	} gated_out_t;

	// predictor state
	logic signed [31:0] h_mem [NL*NC*NS];
	logic signed [31:0] run_sum;
	logic sat_flag;
	logic signed [31:0] floor_q;

	gated_out_t y_expected[$];
	int errors = 0;
	int idle_cycles = 0;
	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_off = 0;

	function automatic logic signed [31:0] clamp32(input logic signed [65:0] x,
			inout logic f);
		if (x > 66'sd2147483647) begin
			f = 1'b1;
			return 32'sh7fffffff;
		end
		if (x < -66'sd2147483648) begin
			f = 1'b1;
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	function automatic logic signed [65:0] fxmul(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] p;
		p = a * b;
		return 66'(p >>> 16);
	endfunction

	task automatic predict_step(input logic [1:0] l, input logic [5:0] c, input logic [3:0] s,
			input logic [30:0] dl, input logic signed [31:0] a, b, cv, u, d, g);
		logic f;
		logic signed [31:0] da, ab, bb, h, hc, tot, y;
		logic signed [63:0] dw;
		int addr;
		f = 1'b0;
		dw = {33'd0, dl};
		addr = (int'(l) * NC + int'(c)) * NS + int'(s);
		da = clamp32(fxmul(dw, 64'(a)), f);
		if (da < floor_q)
			da = floor_q;
		ab = clamp32(66'(da) + 66'sd65536, f);
		bb = clamp32(fxmul(dw, 64'(b)), f);
		h = clamp32(fxmul(64'(ab), 64'(h_mem[addr])) + fxmul(64'(bb), 64'(u)), f);
		h_mem[addr] = h;
		hc = clamp32(fxmul(64'(h), 64'(cv)), f);
		run_sum = clamp32(66'(run_sum) + 66'(hc), f);
		if (f)
			sat_flag = 1'b1;
		if (s == 4'(NS - 1)) begin
			tot = clamp32(66'(run_sum) + fxmul(64'(u), 64'(d)), f);
			y = clamp32(fxmul(64'(tot), 64'(g)), f);
			if (f)
				sat_flag = 1'b1;
			y_expected.push_back('{ch: c, y: y, sat: sat_flag});
			run_sum = '0;
			sat_flag = 1'b0;
		end
	endtask

	task automatic send_step(input logic [1:0] l, input logic [5:0] c, input logic [3:0] s,
			input logic [30:0] dl, input logic signed [31:0] a, b, cv, u, d, g);
		while ($urandom_range(99) < send_gap_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.layer_index <= l;
		in_ch.channel <= c;
		in_ch.state_index <= s;
		in_ch.delta <= dl;
		in_ch.a_coef <= a;
		in_ch.b_val <= b;
		in_ch.c_val <= cv;
		in_ch.u_val <= u;
		in_ch.d_skip <= d;
		in_ch.gate <= g;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict_step(l, c, s, dl, a, b, cv, u, d, g);
		@(negedge clk);
	endtask

	// receiver: random stalls plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_off <= HOLD_LEN - 1;
			out_ch.ready <= 1'b0;
		end else if (hold_off > 0) begin
			out_ch.ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	always @(posedge clk) begin
		gated_out_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (y_expected.size() == 0) begin
				$error("unexpected result: channel %0d y %0d", out_ch.out_channel,
					out_ch.y_out);
				errors++;
			end else begin
				e = y_expected.pop_front();
				if (out_ch.out_channel !== e.ch) begin
					$error("out_channel: expected %0d, got %0d", e.ch, out_ch.out_channel);
					errors++;
				end
				if (out_ch.y_out !== e.y) begin
					$error("y_out: expected %0d, got %0d", e.y, out_ch.y_out);
					errors++;
				end
				if (out_ch.saturated !== e.sat) begin
					$error("saturated: expected %0d, got %0d", e.sat, out_ch.saturated);
					errors++;
				end
			end
		end
	end

	// watchdog: count cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > NL * NC * NS + IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// wait out results and the items still queued behind them
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (y_expected.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_floor(input logic signed [31:0] v);
		drain();
		cfg_ch.we <= 1'b1;
		cfg_ch.wdata <= v;
		@(negedge clk);
		cfg_ch.we <= 1'b0;
		floor_q = v;
	endtask

	function automatic logic signed [31:0] rnd_q();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			default: return $signed(32'($urandom_range(131072))) - 32'sd65536;
		endcase
	endfunction

	function automatic logic [30:0] rnd_delta();
		case ($urandom_range(4))
			0: return 31'($urandom);
			1: return 31'h7fffffff;
			default: return 31'($urandom_range(32768));
		endcase
	endfunction

	task automatic scan_channel(input logic [1:0] l, input logic [5:0] c);
		logic signed [31:0] u, d, g;
		u = rnd_q();
		d = rnd_q();
		g = rnd_q();
		for (int s = 0; s < NS; s++)
			send_step(l, c, 4'(s), rnd_delta(), rnd_q(), rnd_q(), rnd_q(), u, d, g);
	endtask

	task automatic test_extremes();
		send_step(2'd0, 6'd0, 4'd0, 31'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
		send_step(2'd3, 6'd63, 4'd15, 31'h7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_step(2'd3, 6'd63, 4'd15, 31'h7fffffff, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_step(2'd1, 6'd21, 4'd15, 31'h2aaaaaaa, 32'sh55555555, 32'shaaaaaaaa,
			32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa);
		send_step(2'd2, 6'd42, 4'd15, 31'h55555555, 32'shaaaaaaaa, 32'sh55555555,
			32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555);
		// strongly negative decay hits the floor
		send_step(2'd0, 6'd1, 4'd15, 31'h00030000, -32'sd196608, 32'sd65536,
			32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536);
	endtask

	task automatic test_interleave();
		// two channels share the running sum when mixed
		for (int s = 0; s < NS; s++) begin
			send_step(2'd1, 6'd5, 4'(s), rnd_delta(), rnd_q(), rnd_q(), rnd_q(),
				rnd_q(), rnd_q(), rnd_q());
			if (s < 4)
				send_step(2'd2, 6'd9, 4'(s), rnd_delta(), rnd_q(), rnd_q(), rnd_q(),
					rnd_q(), rnd_q(), rnd_q());
		end
	endtask

	task automatic test_random(input int n);
		int sent;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(9) < 8) begin
				scan_channel(2'($urandom), 6'($urandom));
				sent += NS;
			end else begin
				send_step(2'($urandom), 6'($urandom), 4'($urandom), rnd_delta(), rnd_q(),
					rnd_q(), rnd_q(), rnd_q(), rnd_q(), rnd_q());
				sent++;
			end
		end
	endtask

	task automatic test_backpressure();
		hold_reqs++;
		for (int k = 0; k < 4; k++)
			scan_channel(2'($urandom), 6'($urandom));
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.layer_index = '0;
		in_ch.channel = '0;
		in_ch.state_index = '0;
		in_ch.delta = '0;
		in_ch.a_coef = '0;
		in_ch.b_val = '0;
		in_ch.c_val = '0;
		in_ch.u_val = '0;
		in_ch.d_skip = '0;
		in_ch.gate = '0;
		cfg_ch.we = 1'b0;
		cfg_ch.wdata = '0;
		for (int i = 0; i < NL * NC * NS; i++)
			h_mem[i] = '0;
		run_sum = '0;
		sat_flag = 1'b0;
		floor_q = FLOOR_RESET;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		send_gap_pct = 6;
		recv_gap_pct = 84;
		test_extremes();
		test_interleave();
		test_random(500);
		write_floor(32'sh80000000);
		test_random(300);

		send_gap_pct = 84;
		recv_gap_pct = 6;
		write_floor(32'sd0);
		test_extremes();
		test_random(300);
		write_floor(32'sd131072);
		test_random(200);

		send_gap_pct = 0;
		recv_gap_pct = 0;
		test_backpressure();
		write_floor(-32'sd32768);
		test_random(400);
		drain();

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
